>>> rtl/core/ptts_pkg.sv
// types, constants and microcode table of the periodic task tick scheduler
`timescale 1ns / 1ps

package ptts_pkg;

    // item kinds carried in tuser
    localparam logic [1:0] KIND_TICK     = 2'd0;
    localparam logic [1:0] KIND_START    = 2'd1;
    localparam logic [1:0] KIND_SHUTDOWN = 2'd2;

    // event codes
    localparam logic [3:0] EV_TICK  = 4'd0;
    localparam logic [3:0] EV_CHECK = 4'd1;
    localparam logic [3:0] EV_LOW   = 4'd2;
    localparam logic [3:0] EV_CRIT  = 4'd3;
    localparam logic [3:0] EV_TASK0 = 4'd4;

    // configuration register indexes
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 16;
    localparam logic [2:0] REG_REQ_PERIOD    = 3'd0;
    localparam logic [2:0] REG_GLOBAL_PERIOD = 3'd1;
    localparam int REG_TASK_BASE     = 2;
    localparam int NUM_TASK_REGS     = 6;

    localparam logic [15:0] PERIOD_RESET_MS   = 16'd1000;
    localparam logic [15:0] INTERVAL_LONG_MS  = 16'd30000;
    localparam logic [15:0] INTERVAL_SHORT_MS = 16'd5000;

    localparam logic [47:0] GAP_LOW_MS  = 48'd20000;
    localparam logic [47:0] GAP_CRIT_MS = 48'd40000;

    // bit steps of the interval divider, one per dividend bit
    localparam int DIV_BITS = 17;

    // program addresses
    localparam logic [3:0] PC_WAIT     = 4'd0;
    localparam logic [3:0] PC_TICK     = 4'd1;
    localparam logic [3:0] PC_CHECK    = 4'd2;
    localparam logic [3:0] PC_GAPSUB   = 4'd3;
    localparam logic [3:0] PC_GAPCHK   = 4'd4;
    localparam logic [3:0] PC_TASK     = 4'd5;
    localparam logic [3:0] PC_FINISH   = 4'd6;
    localparam logic [3:0] PC_START    = 4'd7;
    localparam logic [3:0] PC_DIVLOAD  = 4'd8;
    localparam logic [3:0] PC_DIVSTEP  = 4'd9;
    localparam logic [3:0] PC_DIVSTORE = 4'd10;
    localparam logic [3:0] PC_STARTFIN = 4'd11;

    typedef enum logic [3:0] {
        OP_WAIT,
        OP_EMIT,
        OP_GAPSUB,
        OP_GAPCHK,
        OP_TASK,
        OP_FINISH,
        OP_PSET,
        OP_DIVLOAD,
        OP_DIVSTEP,
        OP_DIVSTORE,
        OP_STARTFIN,
        OP_NOP
    } t_uop;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NSTART,
        C_TASK_MORE,
        C_DIV_MORE
    } t_ucond;

    typedef struct packed {
        t_uop       op;
        t_ucond     cond;
        logic [3:0] target;
        logic [3:0] code;
    } t_uword;

    function automatic logic [15:0] interval_reset(input int i);
        logic [15:0] v;
        case (i)
            2, 3, 4: v = INTERVAL_SHORT_MS;
            default: v = INTERVAL_LONG_MS;
        endcase
        return v;
    endfunction

    function automatic t_uword ucode(input logic [3:0] pc);
        t_uword w;
        case (pc)
            PC_WAIT:     w = '{OP_WAIT,     C_NEXT,      PC_WAIT,    EV_TICK};
            PC_TICK:     w = '{OP_EMIT,     C_NEXT,      PC_WAIT,    EV_TICK};
            PC_CHECK:    w = '{OP_EMIT,     C_NEXT,      PC_WAIT,    EV_CHECK};
            PC_GAPSUB:   w = '{OP_GAPSUB,   C_NEXT,      PC_WAIT,    EV_TICK};
            PC_GAPCHK:   w = '{OP_GAPCHK,   C_NSTART,    PC_FINISH,  EV_TICK};
            PC_TASK:     w = '{OP_TASK,     C_TASK_MORE, PC_TASK,    EV_TICK};
            PC_FINISH:   w = '{OP_FINISH,   C_ALWAYS,    PC_WAIT,    EV_TICK};
            PC_START:    w = '{OP_PSET,     C_NEXT,      PC_WAIT,    EV_TICK};
            PC_DIVLOAD:  w = '{OP_DIVLOAD,  C_NEXT,      PC_WAIT,    EV_TICK};
            PC_DIVSTEP:  w = '{OP_DIVSTEP,  C_DIV_MORE,  PC_DIVSTEP, EV_TICK};
            PC_DIVSTORE: w = '{OP_DIVSTORE, C_TASK_MORE, PC_DIVLOAD, EV_TICK};
            PC_STARTFIN: w = '{OP_STARTFIN, C_ALWAYS,    PC_WAIT,    EV_TICK};
            default:     w = '{OP_NOP,      C_ALWAYS,    PC_WAIT,    EV_TICK};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/periodic_task_tick_scheduler_unit.sv
// periodic task tick scheduler: microcoded sequencer with task phase counters
`timescale 1ns / 1ps

// A tick request (tuser kind 0, tdata the millisecond time) produces a run of
// events on the master side, tlast on the final one: tick, check data, an
// optional refresh-low or refresh-critical when the gap since the last tick
// exceeds 20000 or 40000 ms, then every task whose tick interval divides the
// tick count. A start request (kind 1) sets the period to the larger of the
// two period registers and converts each task interval to ticks, rounding up;
// a shutdown request (kind 2) silences all later ticks; kind 3 is ignored.
// Requests are taken one at a time by a microcoded step sequencer. A tick runs
// the tick, check, gap subtract, gap check, task loop (only when started) and
// finish steps, stalled while the master side holds tready low; after shutdown
// it stays in the wait step. The task loop spends one step per task. A start
// runs the shared bit-serial divider per task, one quotient bit per cycle over
// 17 bits. Shutdown and ignored requests stay in the wait step. Configuration
// writes are meant for idle periods; task intervals are sampled only at start.
module periodic_task_tick_scheduler_unit #(
    parameter int NUM_TASKS   = 6,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wen,
    input  logic [ptts_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ptts_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // request side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [47:0] now_ms
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    // event side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [3:0] event_res, [7:4] zero
    output logic        m_axis_tlast    // last
);

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_TASKS - 1);

    // configuration registers
    logic [15:0] r_req_period;
    logic [15:0] r_glb_period;
    logic [15:0] r_interval [NUM_TASKS];

    // sequencer and control state
    logic [3:0]             r_pc;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_started;
    logic                   r_shut;
    logic                   r_gapz;     // gap seen this tick: count and phases read as zero
    logic [COUNT_WIDTH-1:0] r_count;
    logic [47:0]            r_last;
    logic                   r_pend_v;
    logic                   r_out_v;

    // datapath
    logic [47:0] r_now;
    logic [48:0] r_diff;
    logic [15:0] r_divisor;
    logic [16:0] r_quo;
    logic [15:0] r_rem;
    logic [4:0]  r_div_cnt;
    logic [15:0] r_ticks [NUM_TASKS];
    logic [15:0] r_phase [NUM_TASKS];   // tick count modulo task ticks
    logic [3:0]  r_pend_code;           // held back until the next event shows it is not last
    logic [3:0]  r_out_code;
    logic        r_out_last;

    logic [3:0]        n_pc;
    ptts_pkg::t_uword  w_uw;
    logic              w_accept;
    logic              w_out_free;
    logic              w_push;
    logic [3:0]        w_code;
    logic              w_need_out;
    logic              w_stall;
    logic              w_more;
    logic [15:0]       w_t;
    logic [15:0]       w_eph;
    logic              w_fire;
    logic [16:0]       w_inc;
    logic [15:0]       w_phase_next;
    logic [4:0]        w_task_code;
    logic              w_gap_hit;
    logic              w_gap_crit;
    logic [15:0]       w_period;
    logic [16:0]       w_shift;
    logic [16:0]       w_sub;
    logic              w_ge;

    assign w_uw          = ptts_pkg::ucode(r_pc);
    assign s_axis_tready = (r_pc == ptts_pkg::PC_WAIT);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_v || m_axis_tready;
    assign w_more        = (r_idx != IDX_LAST);

    // task lane selected by the loop index
    assign w_t          = r_ticks[r_idx];
    assign w_eph        = r_gapz ? 16'd0 : r_phase[r_idx];
    assign w_fire       = (w_t == 16'd0) || (w_eph == 16'd0);
    assign w_inc        = {1'b0, w_eph} + 17'd1;
    // count wrap sends the count back to zero, so the phase follows
    assign w_phase_next = ((&r_count) || (w_inc == {1'b0, w_t})) ? 16'd0 : w_inc[15:0];
    assign w_task_code  = 5'(ptts_pkg::EV_TASK0) + 5'(r_idx);

    // gap check on the registered difference; a borrow means time went back
    assign w_gap_hit  = !r_diff[48] && (r_diff[47:0] > ptts_pkg::GAP_LOW_MS);
    assign w_gap_crit = r_diff[47:0] > ptts_pkg::GAP_CRIT_MS;

    // divider step
    assign w_period = (r_req_period < r_glb_period) ? r_glb_period : r_req_period;
    assign w_shift  = {r_rem, r_quo[16]};
    assign w_ge     = w_shift >= {1'b0, r_divisor};
    assign w_sub    = w_shift - {1'b0, r_divisor};

    // event push requested by the current step
    always_comb begin
        w_push = 1'b0;
        w_code = w_uw.code;
        case (w_uw.op)
            ptts_pkg::OP_EMIT: begin
                w_push = 1'b1;
            end
            ptts_pkg::OP_GAPCHK: begin
                w_push = w_gap_hit;
                w_code = w_gap_crit ? ptts_pkg::EV_CRIT : ptts_pkg::EV_LOW;
            end
            ptts_pkg::OP_TASK: begin
                w_push = w_fire;
                w_code = w_task_code[3:0];
            end
            default: begin
                w_push = 1'b0;
            end
        endcase
    end

    // a push moves the held event out; finish sends the held one as last
    assign w_need_out = (w_push && r_pend_v) || (w_uw.op == ptts_pkg::OP_FINISH);
    assign w_stall    = w_need_out && !w_out_free;

    // step counter: dispatch on the request kind, else the word's jump condition
    always_comb begin
        n_pc = r_pc;
        if (!w_stall) begin
            if (w_uw.op == ptts_pkg::OP_WAIT) begin
                if (w_accept) begin
                    case (s_axis_tuser)
                        ptts_pkg::KIND_TICK:  n_pc = r_shut ? ptts_pkg::PC_WAIT
                                                            : ptts_pkg::PC_TICK;
                        ptts_pkg::KIND_START: n_pc = ptts_pkg::PC_START;
                        default:              n_pc = ptts_pkg::PC_WAIT;
                    endcase
                end
            end else begin
                case (w_uw.cond)
                    ptts_pkg::C_NEXT:      n_pc = r_pc + 4'd1;
                    ptts_pkg::C_ALWAYS:    n_pc = w_uw.target;
                    ptts_pkg::C_NSTART:    n_pc = r_started ? r_pc + 4'd1 : w_uw.target;
                    ptts_pkg::C_TASK_MORE: n_pc = w_more ? w_uw.target : r_pc + 4'd1;
                    ptts_pkg::C_DIV_MORE:  n_pc = (r_div_cnt != 5'd0) ? w_uw.target
                                                                      : r_pc + 4'd1;
                    default:               n_pc = ptts_pkg::PC_WAIT;
                endcase
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_period <= ptts_pkg::PERIOD_RESET_MS;
            r_glb_period <= ptts_pkg::PERIOD_RESET_MS;
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_interval[i] <= ptts_pkg::interval_reset(i);
            end
        end else if (i_cfg_wen) begin
            if (i_cfg_index == ptts_pkg::REG_REQ_PERIOD) begin
                r_req_period <= i_cfg_data;
            end
            if (i_cfg_index == ptts_pkg::REG_GLOBAL_PERIOD) begin
                r_glb_period <= i_cfg_data;
            end
            // tasks past the register list keep their fixed interval
            for (int i = 0; i < NUM_TASKS; i++) begin
                if ((i < ptts_pkg::NUM_TASK_REGS) &&
                    (i_cfg_index == ptts_pkg::CFG_INDEX_W'(ptts_pkg::REG_TASK_BASE + i))) begin
                    r_interval[i] <= i_cfg_data;
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= ptts_pkg::PC_WAIT;
            r_idx     <= '0;
            r_started <= 1'b0;
            r_shut    <= 1'b0;
            r_gapz    <= 1'b0;
            r_count   <= '0;
            r_last    <= '0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_pc <= n_pc;

            // output register, reloaded from the held event
            if (!w_stall && w_need_out) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end

            if (!w_stall && w_push) begin
                r_pend_v <= 1'b1;
            end else if (!w_stall && (w_uw.op == ptts_pkg::OP_FINISH)) begin
                r_pend_v <= 1'b0;
            end

            if (!w_stall) begin
                case (w_uw.op)
                    ptts_pkg::OP_WAIT: begin
                        if (w_accept) begin
                            if (s_axis_tuser == ptts_pkg::KIND_SHUTDOWN) begin
                                r_shut <= 1'b1;
                            end
                            // silenced tick still advances the count
                            if (s_axis_tuser == ptts_pkg::KIND_TICK && r_shut) begin
                                r_count <= r_count + COUNT_WIDTH'(1);
                            end
                        end
                    end
                    ptts_pkg::OP_GAPCHK: begin
                        r_last <= r_now;
                        if (w_gap_hit) begin
                            r_count <= '0;
                            r_gapz  <= 1'b1;
                        end
                    end
                    ptts_pkg::OP_TASK,
                    ptts_pkg::OP_DIVSTORE: begin
                        r_idx <= w_more ? r_idx + IDX_W'(1) : '0;
                    end
                    ptts_pkg::OP_FINISH: begin
                        r_count <= r_count + COUNT_WIDTH'(1);
                        r_gapz  <= 1'b0;
                    end
                    ptts_pkg::OP_PSET: begin
                        r_idx <= '0;
                    end
                    ptts_pkg::OP_STARTFIN: begin
                        r_started <= 1'b1;
                        r_count   <= '0;
                        r_last    <= r_now;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now <= s_axis_tdata;
        end

        if (!w_stall && w_need_out) begin
            r_out_code <= r_pend_code;
            r_out_last <= (w_uw.op == ptts_pkg::OP_FINISH);
        end
        if (!w_stall && w_push) begin
            r_pend_code <= w_code;
        end

        if (!w_stall) begin
            case (w_uw.op)
                ptts_pkg::OP_GAPSUB: begin
                    r_diff <= {1'b0, r_now} - {1'b0, r_last};
                end
                ptts_pkg::OP_TASK: begin
                    r_phase[r_idx] <= w_phase_next;
                end
                ptts_pkg::OP_PSET: begin
                    // zero period converts as a period of one
                    r_divisor <= (w_period == 16'd0) ? 16'd1 : w_period;
                end
                ptts_pkg::OP_DIVLOAD: begin
                    r_quo     <= 17'(r_interval[r_idx]) + 17'(r_divisor) - 17'd1;
                    r_rem     <= '0;
                    r_div_cnt <= 5'(ptts_pkg::DIV_BITS - 1);
                end
                ptts_pkg::OP_DIVSTEP: begin
                    r_rem     <= w_ge ? w_sub[15:0] : w_shift[15:0];
                    r_quo     <= {r_quo[15:0], w_ge};
                    r_div_cnt <= r_div_cnt - 5'd1;
                end
                ptts_pkg::OP_DIVSTORE: begin
                    r_ticks[r_idx] <= r_quo[15:0];
                    r_phase[r_idx] <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {4'b0000, r_out_code};
    assign m_axis_tlast  = r_out_last;

    // the final event of a run leaves nothing held back
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_uw.op == ptts_pkg::OP_FINISH && !w_stall) |=> !r_pend_v)
        else $error("event still held after the final one was sent");

    // a gap forces the count to zero until the tick completes
    a_gap_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gapz |-> (r_count == '0))
        else $error("tick count not zero while a gap is being served");

    // a live tick enters the program at its first emit step
    a_tick_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tuser == ptts_pkg::KIND_TICK && !r_shut)
        |=> (r_pc == ptts_pkg::PC_TICK))
        else $error("tick did not enter the tick program");

    // the divider never sees a zero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == ptts_pkg::PC_DIVSTEP) |-> (r_divisor != 16'd0))
        else $error("zero divisor during interval conversion");

endmodule

>>> sim/periodic_task_tick_scheduler_unit_tb.sv
// self-checking testbench of the periodic task tick scheduler: stream requests in, events out
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_unit_tb;

    localparam int NUM_TASKS       = 6;
    localparam int COUNT_WIDTH     = 32;
    localparam int CLK_HALF_NS     = 5;
    localparam int RESET_CYCLES    = 5;
    // a start runs the divider for every task with no events, so allow well over that
    localparam int SETTLE_CYCLES   = 150;
    localparam int NUM_PHASES      = 10;
    localparam int PHASE_REQUESTS  = 36;
    localparam int NUM_REGS        = ptts_pkg::REG_TASK_BASE + ptts_pkg::NUM_TASK_REGS;
    localparam logic [1:0]  KIND_IGNORED = 2'd3;
    localparam logic [15:0] REG_MAX      = 16'hFFFF;
    localparam logic [47:0] TIME_MAX     = 48'hFFFF_FFFF_FFFF;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic [3:0] code;
        logic       is_last;
    } t_sched_event;

    // predictor of the scheduler plus the queue of events it still owes
    class t_tick_scoreboard;
        logic [15:0]  req_period_ms;
        logic [15:0]  glob_period_ms;
        logic [15:0]  interval_ms [NUM_TASKS];
        logic [COUNT_WIDTH-1:0] tick_count;
        logic [15:0]  task_ticks [NUM_TASKS];
        logic [15:0]  period_ms;
        bit           started;
        bit           shut_down;
        logic [47:0]  last_ms;
        t_sched_event due_events [$];
        int           errors;
        int           events_checked;

        function new();
            req_period_ms  = ptts_pkg::PERIOD_RESET_MS;
            glob_period_ms = ptts_pkg::PERIOD_RESET_MS;
            for (int t = 0; t < NUM_TASKS; t++) begin
                interval_ms[t] = (t >= 2 && t <= 4) ? ptts_pkg::INTERVAL_SHORT_MS
                                                    : ptts_pkg::INTERVAL_LONG_MS;
                task_ticks[t]  = '0;
            end
            tick_count     = '0;
            period_ms      = '0;
            started        = 1'b0;
            shut_down      = 1'b0;
            last_ms        = '0;
            errors         = 0;
            events_checked = 0;
        endfunction

        function void set_reg(input logic [2:0] idx, input logic [15:0] value);
            if (idx == ptts_pkg::REG_REQ_PERIOD) begin
                req_period_ms = value;
            end else if (idx == ptts_pkg::REG_GLOBAL_PERIOD) begin
                glob_period_ms = value;
            end else if (int'(idx) >= ptts_pkg::REG_TASK_BASE && int'(idx) < NUM_REGS) begin
                interval_ms[int'(idx) - ptts_pkg::REG_TASK_BASE] = value;
            end
        endfunction

        function void note_request(input logic [1:0] kind, input logic [47:0] now);
            logic [47:0] gap;
            logic [31:0] divisor;
            logic [3:0]  codes [$];
            case (kind)
                ptts_pkg::KIND_START: begin
                    period_ms = (req_period_ms < glob_period_ms) ? glob_period_ms : req_period_ms;
                    divisor   = (period_ms != 0) ? 32'(period_ms) : 32'd1;
                    for (int t = 0; t < NUM_TASKS; t++)
                        task_ticks[t] = 16'((32'(interval_ms[t]) + divisor - 1) / divisor);
                    started    = 1'b1;
                    tick_count = '0;
                    last_ms    = now;
                end
                ptts_pkg::KIND_SHUTDOWN: begin
                    shut_down = 1'b1;
                end
                ptts_pkg::KIND_TICK: begin
                    if (!shut_down) begin
                        codes.push_back(ptts_pkg::EV_TICK);
                        codes.push_back(ptts_pkg::EV_CHECK);
                        if (now > last_ms) begin
                            gap = now - last_ms;
                            if (gap > ptts_pkg::GAP_LOW_MS) begin
                                codes.push_back((gap > ptts_pkg::GAP_CRIT_MS) ? ptts_pkg::EV_CRIT
                                                                              : ptts_pkg::EV_LOW);
                                tick_count = '0;
                            end
                        end
                        if (started) begin
                            for (int t = 0; t < NUM_TASKS; t++)
                                if (task_ticks[t] == 0 || tick_count % task_ticks[t] == 0)
                                    codes.push_back(4'(ptts_pkg::EV_TASK0 + t));
                        end
                        last_ms = now;
                        for (int k = 0; k < codes.size(); k++)
                            due_events.push_back('{codes[k], k == codes.size() - 1});
                    end
                    tick_count = tick_count + 1'b1;
                end
                default: ;
            endcase
        endfunction

        function void check_event(input logic [3:0] code, input logic last);
            t_sched_event want;
            events_checked++;
            if (due_events.size() == 0) begin
                errors++;
                $display("%0t: event with nothing expected: expected none, actual code %0d last %0b",
                         $time, code, last);
                return;
            end
            want = due_events.pop_front();
            if (code !== want.code) begin
                errors++;
                $display("%0t: event code: expected %0d, actual %0d", $time, want.code, code);
            end
            if (last !== want.is_last) begin
                errors++;
                $display("%0t: event last flag: expected %0b, actual %0b",
                         $time, want.is_last, last);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wen;
    logic [ptts_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [ptts_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // [47:0] now_ms
    logic [1:0]  s_axis_tuser;   // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [3:0] event_res, [7:4] zero
    logic        m_axis_tlast;   // last

    t_tick_scoreboard board;
    t_idle_mode       idle_mode;
    logic [47:0]      clock_ms;     // time of the latest tick or start sent
    int               ticks_sent;
    int               starts_sent;

    periodic_task_tick_scheduler_unit #(
        .NUM_TASKS   (NUM_TASKS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // idle decisions, one draw per cycle, depending on the current idling phase
    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 58;
            IDLE_BOTH:   return $urandom_range(0, 99) < 6;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_ready();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) >= 58;
            IDLE_BOTH:     return $urandom_range(0, 99) >= 6;
            default:       return 1'b1;
        endcase
    endfunction

    // event side: values sampled here are the ones the block saw at this edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_event(m_axis_tdata[3:0], m_axis_tlast);
        m_axis_tready <= i_rst_n ? receiver_ready() : 1'b0;
    end

    // one request, held until the block takes it; random gaps go in front of it
    task automatic send_request(input logic [1:0] kind, input logic [47:0] now);
        while (sender_idles()) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= now;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        board.note_request(kind, now);
        if (kind == ptts_pkg::KIND_TICK || kind == ptts_pkg::KIND_START)
            clock_ms = now;
        if (kind == ptts_pkg::KIND_TICK)
            ticks_sent++;
        if (kind == ptts_pkg::KIND_START)
            starts_sent++;
    endtask

    // register write, only ever issued while the block is idle
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        board.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic write_all_regs(input logic [15:0] value);
        for (int r = 0; r < NUM_REGS; r++)
            write_reg(3'(r), value);
    endtask

    // stop sending, wait for every owed event, then let a trailing start finish
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (board.due_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // next tick time: mostly short steps, with refresh gaps, their edges,
    // steps backwards and the odd fully random time
    function automatic logic [47:0] next_tick_ms();
        int pick;
        logic [47:0] back;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            return clock_ms + 48'($urandom_range(0, 3000));
        end else if (pick < 78) begin
            case ($urandom_range(0, 3))
                0:       return clock_ms + ptts_pkg::GAP_LOW_MS;
                1:       return clock_ms + ptts_pkg::GAP_LOW_MS + 1'b1;
                2:       return clock_ms + ptts_pkg::GAP_CRIT_MS;
                default: return clock_ms + ptts_pkg::GAP_CRIT_MS + 1'b1;
            endcase
        end else if (pick < 85) begin
            return clock_ms + 48'($urandom_range(20001, 40000));
        end else if (pick < 90) begin
            return clock_ms + 48'($urandom_range(40001, 1000000));
        end else if (pick < 95) begin
            back = (clock_ms > 48'd50000) ? 48'($urandom_range(1, 50000)) : clock_ms;
            return clock_ms - back;
        end
        return {16'($urandom()), 32'($urandom())};
    endfunction

    // register setting for one random phase, the extremes among them
    task automatic program_phase(input int phase);
        int pick;
        case (phase)
            0: ;                             // keep the reset values
            1: write_all_regs(REG_MAX);
            2: write_all_regs(16'd1);
            3: begin
                // shortest period against a mix of wide and narrow intervals
                write_reg(ptts_pkg::REG_REQ_PERIOD, 16'd1);
                write_reg(ptts_pkg::REG_GLOBAL_PERIOD, 16'd1);
                write_reg(3'(ptts_pkg::REG_TASK_BASE + 0), REG_MAX);
                write_reg(3'(ptts_pkg::REG_TASK_BASE + 1), 16'd1);
                write_reg(3'(ptts_pkg::REG_TASK_BASE + 2), 16'h8000);
                write_reg(3'(ptts_pkg::REG_TASK_BASE + 3), 16'd3);
                write_reg(3'(ptts_pkg::REG_TASK_BASE + 4), 16'd2);
                write_reg(3'(ptts_pkg::REG_TASK_BASE + 5), 16'd7);
            end
            4: begin
                // global period wins over a small requested one
                write_reg(ptts_pkg::REG_REQ_PERIOD, 16'd1);
                write_reg(ptts_pkg::REG_GLOBAL_PERIOD, REG_MAX);
            end
            default: begin
                write_reg(ptts_pkg::REG_REQ_PERIOD, 16'($urandom_range(1, 2000)));
                write_reg(ptts_pkg::REG_GLOBAL_PERIOD, 16'($urandom_range(1, 2000)));
                for (int t = 0; t < ptts_pkg::NUM_TASK_REGS; t++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 80)
                        write_reg(3'(ptts_pkg::REG_TASK_BASE + t), 16'($urandom_range(1, 8000)));
                    else if (pick < 95)
                        write_reg(3'(ptts_pkg::REG_TASK_BASE + t), 16'($urandom_range(0, 65535)));
                    else
                        write_reg(3'(ptts_pkg::REG_TASK_BASE + t), 16'd0);
                end
            end
        endcase
    endtask

    task automatic run_directed();
        // before any start: refresh events, no task events
        send_request(ptts_pkg::KIND_TICK, 48'd0);          // same time as reset, no gap
        send_request(ptts_pkg::KIND_TICK, 48'd20000);      // gap exactly at the low bound
        send_request(ptts_pkg::KIND_TICK, 48'd40001);      // just over it: refresh low
        send_request(ptts_pkg::KIND_TICK, 48'd80001);      // exactly the critical bound: still low
        send_request(ptts_pkg::KIND_TICK, 48'd120002);     // just over: refresh critical
        send_request(ptts_pkg::KIND_TICK, 48'd100000);     // time going backwards
        send_request(KIND_IGNORED, TIME_MAX);              // unknown kind, ignored
        send_request(ptts_pkg::KIND_TICK, TIME_MAX);       // largest time, huge gap
        // start with reset registers, then ordinary ticks
        send_request(ptts_pkg::KIND_START, 48'd5);
        for (int k = 1; k <= 7; k++)
            send_request(ptts_pkg::KIND_TICK, 48'(5 + k * 1000));
        quiesce();
        // both periods zero, some task intervals zero
        write_reg(ptts_pkg::REG_REQ_PERIOD, 16'd0);
        write_reg(ptts_pkg::REG_GLOBAL_PERIOD, 16'd0);
        write_reg(3'(ptts_pkg::REG_TASK_BASE + 0), 16'd0);
        write_reg(3'(ptts_pkg::REG_TASK_BASE + 1), REG_MAX);
        write_reg(3'(ptts_pkg::REG_TASK_BASE + 2), 16'd1);
        write_reg(3'(ptts_pkg::REG_TASK_BASE + 3), 16'd2);
        write_reg(3'(ptts_pkg::REG_TASK_BASE + 4), 16'd3);
        write_reg(3'(ptts_pkg::REG_TASK_BASE + 5), 16'd0);
        send_request(ptts_pkg::KIND_START, 48'd200);
        for (int k = 1; k <= 4; k++)
            send_request(ptts_pkg::KIND_TICK, 48'(200 + k));
        quiesce();
    endtask

    task automatic run_random();
        int sent;
        int pick;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            idle_mode = t_idle_mode'(phase % 4);
            program_phase(phase);
            // one phase keeps the earlier conversion: registers are sampled at start only
            if (phase != 5)
                send_request(ptts_pkg::KIND_START, next_tick_ms());
            sent = 0;
            while (sent < PHASE_REQUESTS) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    send_request(KIND_IGNORED, {16'($urandom()), 32'($urandom())});
                end else if (pick < 10) begin
                    send_request(ptts_pkg::KIND_START, next_tick_ms());
                    sent++;
                end else begin
                    send_request(ptts_pkg::KIND_TICK, next_tick_ms());
                    sent++;
                end
            end
            quiesce();
        end
    endtask

    initial begin
        board         = new();
        idle_mode     = IDLE_NONE;
        clock_ms      = '0;
        ticks_sent    = 0;
        starts_sent   = 0;
        i_rst_n       <= 1'b0;
        i_cfg_wen     <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ptts_pkg::KIND_TICK;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_random();

        // shutdown comes last, as it silences every tick after it
        idle_mode = IDLE_BOTH;
        send_request(ptts_pkg::KIND_SHUTDOWN, clock_ms);
        for (int k = 0; k < 3; k++)
            send_request(ptts_pkg::KIND_TICK, next_tick_ms());
        send_request(ptts_pkg::KIND_START, next_tick_ms());
        send_request(ptts_pkg::KIND_TICK, next_tick_ms());
        send_request(KIND_IGNORED, '0);
        quiesce();

        if (board.due_events.size() != 0) begin
            $display("%0t: events never delivered: expected %0d more, actual 0",
                     $time, board.due_events.size());
            board.errors += board.due_events.size();
        end
        $display("covered %0d ticks and %0d starts over %0d register phases and four idling modes",
                 ticks_sent, starts_sent, NUM_PHASES);
        $display("%0d events checked, %0d mismatches", board.events_checked, board.errors);
        if (board.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("%0t: timeout with %0d events outstanding", $time, board.due_events.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
